// File: src/mcc_pkg.sv
// mcc_pkg: shared types and helpers for the minimum coin change block
// table cell encoding, sequencer states and cell arithmetic
// no dependencies
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned GUARD_W = 9;

  // one table entry: fewest coins, or the saturated infinity flag
  typedef struct packed {
    logic             inf;
    logic [CNT_W-1:0] cnt;
  } dp_cell_t;

  localparam dp_cell_t CELL_ZERO = '{inf: 1'b0, cnt: '0};
  localparam dp_cell_t CELL_ONE  = '{inf: 1'b0, cnt: CNT_W'(1)};
  localparam dp_cell_t CELL_INF  = '{inf: 1'b1, cnt: '0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TOT_RD,
    ST_TOT,
    ST_TB_CHK,
    ST_TB_EV,
    ST_OUT
  } state_e;

  function automatic dp_cell_t cell_inc(input dp_cell_t v);
    dp_cell_t r;
    if (v.inf) begin
      r = CELL_INF;
    end else begin
      r = '{inf: 1'b0, cnt: v.cnt + CNT_W'(1)};
    end
    return r;
  endfunction

  // keeps the entry without the coin only when strictly better
  function automatic dp_cell_t cell_min(input dp_cell_t above, input dp_cell_t with_c);
    logic lt;
    if (above.inf) begin
      lt = 1'b0;
    end else if (with_c.inf) begin
      lt = 1'b1;
    end else begin
      lt = above.cnt < with_c.cnt;
    end
    return lt ? above : with_c;
  endfunction

endpackage

// File: src/min_coin_change_dp.sv
// min_coin_change_dp: minimum coin change with table fill and traceback
// depends on mcc_pkg for cell types, states and cell arithmetic
//
// usage:
//   coin requests arrive on in_valid_i / in_ready_o with coin_value_i and
//   is_last_coin_i. coins are stored in loading order; coins past
//   MAX_COIN_KINDS are dropped. the target amount is written on the
//   cfg_valid_i / cfg_ready_o channel (always ready) while the block is idle.
//   a request with is_last_coin_i set starts the computation; in_ready_o stays
//   low until every result of the batch has been taken.
// sequence: a coin that is not last is simply stored. the last coin starts a
//   fill of kinds * amount cells (none for a zero amount), each read, then
//   updated through the single compare/increment unit and the table's write
//   port, then a read of the total, then a traceback of at most
//   kinds + amount + 1 steps, then one result per coin kind, one per cycle at best (while out_ready_i is high).
// reset clears the coin count, the target amount and the use counters; the
//   table needs no clearing pass since every entry read was written first.
// a stalled receiver holds the current result on the outputs unchanged.
`timescale 1ns / 1ps

module min_coin_change_dp #(
  parameter int unsigned MAX_COIN_KINDS = 8,
  parameter int unsigned MAX_AMOUNT     = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] target_amount_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] coin_value_i,
  input  logic       is_last_coin_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] coin_index_o,
  output logic [7:0] coin_amount_o,
  output logic [7:0] use_count_o,
  output logic [7:0] total_coins_o,
  output logic       unreachable_o,
  output logic       last_result_o
);

  localparam int unsigned AMT_MAX = (MAX_AMOUNT < 255) ? MAX_AMOUNT : 255;
  localparam int unsigned AMT_W   = (AMT_MAX > 1) ? $clog2(AMT_MAX + 1) : 1;
  localparam int unsigned KW      = $clog2(MAX_COIN_KINDS + 1);
  localparam int unsigned IW      = (MAX_COIN_KINDS > 1) ? $clog2(MAX_COIN_KINDS) : 1;
  localparam int unsigned ADDR_W  = KW + AMT_W;
  localparam int unsigned CNT_W   = mcc_pkg::CNT_W;
  localparam int unsigned GUARD_W = mcc_pkg::GUARD_W;

  mcc_pkg::state_e state_q, state_d;

  logic [7:0]         coin_store_q [MAX_COIN_KINDS];
  logic [CNT_W-1:0]   use_q        [MAX_COIN_KINDS];
  logic [CNT_W-1:0]   use_d        [MAX_COIN_KINDS];
  mcc_pkg::dp_cell_t  dp_mem       [2**ADDR_W];

  logic [7:0]         target_q;
  logic [KW-1:0]      count_q, count_d;
  logic [KW-1:0]      kinds_q, kinds_d;
  logic [AMT_W-1:0]   amt_q, amt_d;
  logic [KW-1:0]      k_q, k_d;
  logic [AMT_W-1:0]   a_q, a_d;
  logic [IW-1:0]      out_idx_q, out_idx_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  mcc_pkg::dp_cell_t  total_q, total_d;

  mcc_pkg::dp_cell_t  rd0_q, rd1_q;
  logic [ADDR_W-1:0]  ra0, ra1, wa;
  mcc_pkg::dp_cell_t  wd;
  logic               mem_we;

  logic [KW-1:0]      km1;
  logic [KW-1:0]      kinds_m1;
  logic [IW-1:0]      coin_idx;
  logic [7:0]         coin_m;
  logic               usable;
  logic [7:0]         diff;
  logic [AMT_W-1:0]   amt_new;
  logic               store_wr;
  mcc_pkg::dp_cell_t  above, with_c, tot;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == mcc_pkg::ST_IDLE);
  assign out_valid_o = (state_q == mcc_pkg::ST_OUT);

  assign km1      = k_q - KW'(1);
  assign kinds_m1 = kinds_q - KW'(1);
  assign coin_idx = (state_q == mcc_pkg::ST_OUT) ? out_idx_q : km1[IW-1:0];
  assign coin_m   = coin_store_q[coin_idx];
  assign usable   = (coin_m != 8'd0) && (coin_m <= 8'(a_q));
  assign diff     = 8'(a_q) - coin_m;
  assign amt_new  = (target_q > 8'(AMT_MAX)) ? AMT_W'(AMT_MAX) : AMT_W'(target_q);
  assign store_wr = in_valid_i && in_ready_o && (count_q < KW'(MAX_COIN_KINDS));

  assign coin_index_o  = 3'(out_idx_q);
  assign coin_amount_o = coin_m;
  assign use_count_o   = total_q.inf ? 8'd0 : 8'(use_q[out_idx_q]);
  assign total_coins_o = total_q.inf ? 8'd0 : 8'(total_q.cnt);
  assign unreachable_o = total_q.inf;
  assign last_result_o = (out_idx_q == kinds_m1[IW-1:0]);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    kinds_d   = kinds_q;
    amt_d     = amt_q;
    k_d       = k_q;
    a_d       = a_q;
    out_idx_d = out_idx_q;
    guard_d   = guard_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    use_d     = use_q;
    mem_we    = 1'b0;
    wa        = '0;
    wd        = mcc_pkg::CELL_ZERO;
    ra0       = '0;
    ra1       = '0;
    above     = mcc_pkg::CELL_INF;
    with_c    = mcc_pkg::CELL_INF;
    tot       = mcc_pkg::CELL_ZERO;

    unique case (state_q)
      mcc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (store_wr) begin
            count_d = count_q + KW'(1);
          end
          if (is_last_coin_i) begin
            kinds_d   = count_d;
            amt_d     = amt_new;
            k_d       = KW'(1);
            a_d       = AMT_W'(1);
            out_idx_d = '0;
            for (int i = 0; i < MAX_COIN_KINDS; i++) begin
              use_d[i] = '0;
            end
            state_d = (amt_new == '0) ? mcc_pkg::ST_TOT_RD : mcc_pkg::ST_FILL_RD;
          end
        end
      end

      mcc_pkg::ST_FILL_RD: begin
        ra0     = {km1, a_q};
        ra1     = {k_q, diff[AMT_W-1:0]};
        state_d = mcc_pkg::ST_FILL_WR;
      end

      mcc_pkg::ST_FILL_WR: begin
        // row zero and column zero are implied, never stored
        above  = (k_q == KW'(1)) ? mcc_pkg::CELL_INF : rd0_q;
        with_c = (diff == 8'd0) ? mcc_pkg::CELL_ONE : mcc_pkg::cell_inc(rd1_q);
        mem_we = 1'b1;
        wa     = {k_q, a_q};
        wd     = usable ? mcc_pkg::cell_min(above, with_c) : above;
        if (a_q == amt_q) begin
          if (k_q == kinds_q) begin
            state_d = mcc_pkg::ST_TOT_RD;
          end else begin
            k_d     = k_q + KW'(1);
            a_d     = AMT_W'(1);
            state_d = mcc_pkg::ST_FILL_RD;
          end
        end else begin
          a_d     = a_q + AMT_W'(1);
          state_d = mcc_pkg::ST_FILL_RD;
        end
      end

      mcc_pkg::ST_TOT_RD: begin
        ra0     = {kinds_q, amt_q};
        state_d = mcc_pkg::ST_TOT;
      end

      mcc_pkg::ST_TOT: begin
        tot     = (amt_q == '0) ? mcc_pkg::CELL_ZERO : rd0_q;
        total_d = tot;
        if (tot.inf) begin
          state_d = mcc_pkg::ST_OUT;
        end else begin
          k_d     = kinds_q;
          a_d     = amt_q;
          guard_d = GUARD_W'(kinds_q) + GUARD_W'(amt_q) + GUARD_W'(1);
          cnt_d   = '0;
          state_d = mcc_pkg::ST_TB_CHK;
        end
      end

      mcc_pkg::ST_TB_CHK: begin
        if (a_q == '0 || guard_q == '0) begin
          use_d[km1[IW-1:0]] = cnt_q;
          state_d = mcc_pkg::ST_OUT;
        end else begin
          ra0     = {k_q, a_q};
          ra1     = {km1, a_q};
          state_d = mcc_pkg::ST_TB_EV;
        end
      end

      mcc_pkg::ST_TB_EV: begin
        guard_d = guard_q - GUARD_W'(1);
        if (k_q > KW'(1) && rd0_q == rd1_q) begin
          // same entry without this kind: move up a row
          use_d[km1[IW-1:0]] = cnt_q;
          cnt_d   = '0;
          k_d     = km1;
          state_d = mcc_pkg::ST_TB_CHK;
        end else if (!usable) begin
          use_d[km1[IW-1:0]] = cnt_q;
          state_d = mcc_pkg::ST_OUT;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          a_d     = diff[AMT_W-1:0];
          state_d = mcc_pkg::ST_TB_CHK;
        end
      end

      mcc_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (out_idx_q == kinds_m1[IW-1:0]) begin
            count_d = '0;
            state_d = mcc_pkg::ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + IW'(1);
          end
        end
      end

      default: begin
        state_d = mcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mcc_pkg::ST_IDLE;
      target_q  <= '0;
      count_q   <= '0;
      kinds_q   <= '0;
      amt_q     <= '0;
      k_q       <= '0;
      a_q       <= '0;
      out_idx_q <= '0;
      guard_q   <= '0;
      cnt_q     <= '0;
      total_q   <= mcc_pkg::CELL_ZERO;
      for (int i = 0; i < MAX_COIN_KINDS; i++) begin
        use_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      kinds_q   <= kinds_d;
      amt_q     <= amt_d;
      k_q       <= k_d;
      a_q       <= a_d;
      out_idx_q <= out_idx_d;
      guard_q   <= guard_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      use_q     <= use_d;
      if (cfg_valid_i) begin
        target_q <= target_amount_i;
      end
    end
  end

  // coin denominations, loading order
  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      coin_store_q[count_q[IW-1:0]] <= coin_value_i;
    end
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dp_mem[wa] <= wd;
    end
    rd0_q <= dp_mem[ra0];
    rd1_q <= dp_mem[ra1];
  end

endmodule

// File: tb/sv/min_coin_change_checker.sv
// min_coin_change_checker: watches the config, coin and result channels of min_coin_change_dp
// keeps its own coin table and change solver, compares each result field by field
// no dependencies beyond the channel signals
`timescale 1ns / 1ps

module min_coin_change_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  target_amount_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  coin_value_i,
  input  logic        is_last_coin_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  coin_index_i,
  input  logic [7:0]  coin_amount_i,
  input  logic [7:0]  use_count_i,
  input  logic [7:0]  total_coins_i,
  input  logic        unreachable_i,
  input  logic        last_result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned KINDS_MAX  = 8;
  localparam int unsigned AMOUNT_MAX = 255;
  localparam int unsigned INF_COINS  = 10000;

  typedef struct packed {
    logic [2:0] idx;
    logic [7:0] amount;
    logic [7:0] uses;
    logic [7:0] total;
    logic       no_way;
    logic       last;
  } change_result_t;

  change_result_t change_q[$];
  logic [7:0]     loaded_coins [KINDS_MAX];
  int unsigned    loaded_n;
  logic [7:0]     target_reg;
  int unsigned    min_coins [0:KINDS_MAX][0:AMOUNT_MAX];
  int unsigned    coin_uses [KINDS_MAX];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    loaded_n     = 0;
    target_reg   = '0;
  end

  // fills the fewest-coins table for the loaded batch, traces back and queues one
  // result per loaded coin kind
  task solve_change();
    int unsigned    kinds;
    int unsigned    amount;
    int unsigned    total;
    int unsigned    k;
    int unsigned    a;
    int unsigned    m;
    int unsigned    guard;
    int unsigned    above;
    int unsigned    with_c;
    bit             no_way;
    change_result_t r;
    kinds  = loaded_n;
    amount = (target_reg > AMOUNT_MAX) ? AMOUNT_MAX : target_reg;
    min_coins[0][0] = 0;
    for (a = 1; a <= amount; a++) min_coins[0][a] = INF_COINS;
    for (k = 1; k <= kinds; k++) begin
      m = loaded_coins[k-1];
      min_coins[k][0] = 0;
      for (a = 1; a <= amount; a++) begin
        above = min_coins[k-1][a];
        if (m == 0 || m > a) begin
          min_coins[k][a] = above;
        end else begin
          with_c = (min_coins[k][a-m] >= INF_COINS) ? INF_COINS : min_coins[k][a-m] + 1;
          // a tie goes to the newer coin
          min_coins[k][a] = (above < with_c) ? above : with_c;
        end
      end
    end
    total  = min_coins[kinds][amount];
    no_way = (total >= INF_COINS);
    for (k = 0; k < KINDS_MAX; k++) coin_uses[k] = 0;
    if (!no_way) begin
      k     = kinds;
      a     = amount;
      guard = kinds + amount + 1;
      while (a > 0 && guard > 0) begin
        guard--;
        if (k > 1 && min_coins[k][a] == min_coins[k-1][a]) begin
          k--;
        end else begin
          m = loaded_coins[k-1];
          if (m == 0 || m > a) break;
          coin_uses[k-1]++;
          a -= m;
        end
      end
    end
    for (k = 0; k < kinds; k++) begin
      r.idx    = 3'(k);
      r.amount = loaded_coins[k];
      r.uses   = no_way ? 8'd0 : 8'(coin_uses[k]);
      r.total  = no_way ? 8'd0 : 8'(total);
      r.no_way = no_way;
      r.last   = (k + 1 == kinds);
      change_q.push_back(r);
    end
    loaded_n = 0;
  endtask

  function automatic bit field_bad(input string name, input logic [7:0] want,
                                   input logic [7:0] got);
    bit bad;
    bad = (got !== want);
    if (bad) $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return bad;
  endfunction

  always @(posedge clk_i) begin : monitor
    change_result_t want;
    bit             bad;
    if (!rst_ni) begin
      loaded_n   = 0;
      target_reg = '0;
      change_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) target_reg = target_amount_i;
      if (in_valid_i && in_ready_i) begin
        // a full store drops the coin but a last flag still starts the batch
        if (loaded_n < KINDS_MAX) begin
          loaded_coins[loaded_n] = coin_value_i;
          loaded_n++;
        end
        if (is_last_coin_i) solve_change();
      end
      if (out_valid_i && out_ready_i) begin
        if (change_q.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result for coin index %0d with nothing expected, got amount %0d",
                   $time, coin_index_i, coin_amount_i);
        end else begin
          want = change_q.pop_front();
          bad  = field_bad("coin_index", 8'(want.idx), 8'(coin_index_i))
               | field_bad("coin_amount", want.amount, coin_amount_i)
               | field_bad("use_count", want.uses, use_count_i)
               | field_bad("total_coins", want.total, total_coins_i)
               | field_bad("unreachable", 8'(want.no_way), 8'(unreachable_i))
               | field_bad("last_result", 8'(want.last), 8'(last_result_i));
          if (bad) fail_count_o++;
          checked_o++;
        end
      end
    end
    pending_o = change_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// tb: stimulus and verdict for min_coin_change_dp, directed batches then random ones
// depends on min_coin_change_dp and min_coin_change_checker
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned RX_HOLD_CYCLES = 600;
  localparam int unsigned PHASE_COINS    = 60;
  localparam longint unsigned TIMEOUT_NS = 64'd4_000_000;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_valid_i     = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] target_amount_i = '0;
  logic       in_valid_i      = 1'b0;
  logic       in_ready_o;
  logic [7:0] coin_value_i    = '0;
  logic       is_last_coin_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i     = 1'b0;
  logic [2:0] coin_index_o;
  logic [7:0] coin_amount_o;
  logic [7:0] use_count_o;
  logic [7:0] total_coins_o;
  logic       unreachable_o;
  logic       last_result_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned tx_idle_pct = 9;
  int unsigned rx_idle_pct = 56;
  logic        rx_hold     = 1'b0;
  bit          hold_armed  = 1'b0;
  int unsigned coins_sent  = 0;
  int unsigned batches     = 0;
  logic [7:0]  batch_q[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  min_coin_change_dp u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .target_amount_i(target_amount_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .coin_value_i   (coin_value_i),
    .is_last_coin_i (is_last_coin_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coin_index_o   (coin_index_o),
    .coin_amount_o  (coin_amount_o),
    .use_count_o    (use_count_o),
    .total_coins_o  (total_coins_o),
    .unreachable_o  (unreachable_o),
    .last_result_o  (last_result_o)
  );

  min_coin_change_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .target_amount_i(target_amount_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .coin_value_i   (coin_value_i),
    .is_last_coin_i (is_last_coin_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coin_index_i   (coin_index_o),
    .coin_amount_i  (coin_amount_o),
    .use_count_i    (use_count_o),
    .total_coins_i  (total_coins_o),
    .unreachable_i  (unreachable_o),
    .last_result_i  (last_result_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // result side back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // one long receiver stall so the block fills and holds off the next coin requests
  initial begin : rx_pressure
    wait (hold_armed);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("min_coin_change_dp regression: fail");
    $finish;
  end

  task automatic send_coin(input logic [7:0] value, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    coin_value_i   <= value;
    is_last_coin_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    coins_sent++;
  endtask

  task automatic send_batch();
    for (int i = 0; i < batch_q.size(); i++) send_coin(batch_q[i], i == batch_q.size() - 1);
    batches++;
  endtask

  // target changes only once the block has drained
  task automatic set_target(input logic [7:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    target_amount_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small coins so targets stay reachable in interesting ways
  function automatic logic [7:0] pick_coin();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(20, 1));
    if (r < 90) return 8'($urandom_range(60, 1));
    return 8'($urandom_range(255, 1));
  endfunction

  // small targets keep the table fill short, a few go to the top
  function automatic logic [7:0] pick_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(40, 0));
    if (r < 90) return 8'($urandom_range(120, 41));
    return 8'($urandom_range(255, 121));
  endfunction

  task automatic send_random_batch();
    int unsigned kinds;
    kinds = ($urandom_range(9) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
    batch_q.delete();
    repeat (kinds) batch_q.push_back(pick_coin());
    send_batch();
  endtask

  task automatic run_random_phase(input int unsigned n_coins);
    int unsigned start;
    start = coins_sent;
    while (coins_sent - start < n_coins) begin
      if ($urandom_range(1) == 0) set_target(pick_target());
      send_random_batch();
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed batches
    set_target(8'd0);
    batch_q = '{8'd5, 8'd3};
    send_batch();
    set_target(8'd11);
    batch_q = '{8'd1, 8'd5, 8'd7};
    send_batch();
    // repeated coins exercise the tie rules in fill and traceback
    set_target(8'd8);
    batch_q = '{8'd2, 8'd2, 8'd4};
    send_batch();
    // odd target from even coins, plus a zero coin that is never usable
    set_target(8'd7);
    batch_q = '{8'd0, 8'd2, 8'd4};
    send_batch();
    set_target(8'd255);
    batch_q = '{8'd1};
    send_batch();
    // ninth coin overflows the store and is dropped
    batch_q = '{8'd3, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29, 8'd128};
    send_batch();
    batch_q = '{8'd255, 8'd128, 8'd64};
    send_batch();

    run_random_phase(PHASE_COINS);

    set_target(pick_target());
    @(posedge clk_i);
    tx_idle_pct = 56;
    rx_idle_pct = 9;
    run_random_phase(PHASE_COINS);

    set_target(8'd30);
    @(posedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed  = 1'b1;
    run_random_phase(PHASE_COINS);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d coin requests in %0d batches, %0d results checked,",
             coins_sent, batches, checked);
    $display("targets from 0 to 255, full and overflowing stores, random and held stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("min_coin_change_dp regression: pass");
    end else begin
      $display("min_coin_change_dp regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mcc_pkg.sv
src/min_coin_change_dp.sv
tb/sv/min_coin_change_checker.sv
tb/sv/tb.sv
